[rtl/core/mer_pkg.sv]
package mer_pkg;

  localparam int CENTER_W  = 10;
  localparam int COLOR_W   = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  // Register map, one word per register at byte address 4*index.
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_COLOR = 3'd4;

  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd200;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd200;
  localparam int                  RADIUS_X_RST = 150;
  localparam int                  RADIUS_Y_RST = 100;
  localparam logic [COLOR_W-1:0]  COLOR_RST    = 4'd7;

  // Quadrant of the pixel being emitted; the last one closes the group.
  localparam logic [1:0] QUAD_LAST = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_R0, S_R1, S_R2, S_R3,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5,
    S_S0, S_S1, S_S2,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
    S_CHK,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_RX2,
    MUL_RY2,
    MUL_RX2_Y,
    MUL_RY2_X,
    MUL_RY_2X1,
    MUL_RX_YM1,
    MUL_RX_RY,
    MUL_PSQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    DEC_HOLD,
    DEC_LOAD_P,
    DEC_ADD_P4,
    DEC_SUB_P4,
    DEC_ADD_P8,
    DEC_SUB_P8,
    DEC_ADD_K
  } dec_op_t;

  typedef struct packed {
    mul_sel_t   mul_sel;
    dec_op_t    dec_op;
    logic       start;
    logic       step;
    logic       ld_rx2;
    logic       ld_ry2;
    logic       ld_hold;
    logic       set_reg2;
    logic       set_fin;
    logic       emit;
    logic [1:0] quad;
  } dp_cmd_t;

  typedef struct packed {
    logic fin;
    logic reg2;
    logic lt;
    logic done_chk;
    logic term_ry;
    logic term_rx;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/mer_regs.sv]
module mer_regs #(
  parameter int RADIUS_BITS = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mer_pkg::ADDR_W-1:0]   paddr,
  input  logic [mer_pkg::DATA_W-1:0]   pwdata,
  output logic [mer_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [mer_pkg::CENTER_W-1:0] center_x,
  output logic [mer_pkg::CENTER_W-1:0] center_y,
  output logic [RADIUS_BITS-1:0]       radius_x,
  output logic [RADIUS_BITS-1:0]       radius_y,
  output logic [mer_pkg::COLOR_W-1:0]  pixel_color
);
  import mer_pkg::*;

  logic [CENTER_W-1:0]    center_x_r;
  logic [CENTER_W-1:0]    center_y_r;
  logic [RADIUS_BITS-1:0] radius_x_r;
  logic [RADIUS_BITS-1:0] radius_y_r;
  logic [COLOR_W-1:0]     color_r;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      radius_x_r <= RADIUS_BITS'(RADIUS_X_RST);
      radius_y_r <= RADIUS_BITS'(RADIUS_Y_RST);
      color_r    <= COLOR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER_X:    center_x_r <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:    center_y_r <= pwdata[CENTER_W-1:0];
        REG_RADIUS_X:    radius_x_r <= pwdata[RADIUS_BITS-1:0];
        REG_RADIUS_Y:    radius_y_r <= pwdata[RADIUS_BITS-1:0];
        REG_PIXEL_COLOR: color_r    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X:    prdata = DATA_W'(center_x_r);
      REG_CENTER_Y:    prdata = DATA_W'(center_y_r);
      REG_RADIUS_X:    prdata = DATA_W'(radius_x_r);
      REG_RADIUS_Y:    prdata = DATA_W'(radius_y_r);
      REG_PIXEL_COLOR: prdata = DATA_W'(color_r);
      default:         prdata = '0;
    endcase
  end

  assign center_x    = center_x_r;
  assign center_y    = center_y_r;
  assign radius_x    = radius_x_r;
  assign radius_y    = radius_y_r;
  assign pixel_color = color_r;

endmodule

[rtl/core/mer_dpath.sv]
module mer_dpath #(
  parameter int RADIUS_BITS = 9,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mer_pkg::CENTER_W-1:0]  center_x,
  input  logic [mer_pkg::CENTER_W-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic [mer_pkg::COLOR_W-1:0]   pixel_color,
  input  mer_pkg::dp_cmd_t              cmd,
  output mer_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_pixel_x,
  output logic signed [COORD_BITS-1:0]  out_pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]   out_color,
  output logic                          out_last,
  output logic                          out_done_res
);
  import mer_pkg::*;

  localparam int XW    = RADIUS_BITS + 1;
  localparam int SQW   = 2 * RADIUS_BITS;
  localparam int MW    = 2 * RADIUS_BITS + 2;
  localparam int PW    = 2 * MW;
  localparam int DEC_W = 4 * RADIUS_BITS + 12;

  logic [XW-1:0]             x_r, x_nxt;
  logic [XW-1:0]             y_r, y_nxt;
  logic [XW-1:0]             y_m1;
  logic [SQW-1:0]            rx2_r, ry2_r;
  logic [PW-1:0]             prod_r, hold_r;
  logic [PW-1:0]             mul_p;
  logic [MW-1:0]             mul_a, mul_b;
  logic signed [DEC_W-1:0]   dec_r, dec_nxt;
  logic signed [DEC_W-1:0]   p_ext, k_ext;
  logic                      reg2_r, reg2_nxt;
  logic                      fin_r, fin_nxt;
  logic                      term_ry_r, term_ry_nxt;
  logic                      term_rx_r, term_rx_nxt;
  logic                      dec_neg, dec_pos;

  logic                      out_valid_r;
  logic [COORD_BITS-1:0]     out_px_r, out_py_r;
  logic [COORD_BITS-1:0]     px, py, cx_c, cy_c, x_c, y_c;
  logic [COLOR_W-1:0]        out_color_r;
  logic                      out_last_r, out_done_r;
  logic                      out_free;

  assign y_m1 = (y_r == '0) ? XW'(1) : y_r - XW'(1);

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RX2:    begin mul_a = MW'(radius_x); mul_b = MW'(radius_x); end
      MUL_RY2:    begin mul_a = MW'(radius_y); mul_b = MW'(radius_y); end
      MUL_RX2_Y:  begin mul_a = MW'(rx2_r);    mul_b = MW'(y_r);      end
      MUL_RY2_X:  begin mul_a = MW'(ry2_r);    mul_b = MW'(x_r);      end
      MUL_RY_2X1: begin mul_a = MW'(radius_y); mul_b = MW'({x_r, 1'b1}); end
      MUL_RX_YM1: begin mul_a = MW'(radius_x); mul_b = MW'(y_m1);     end
      MUL_RX_RY:  begin mul_a = MW'(radius_x); mul_b = MW'(radius_y); end
      MUL_PSQ:    begin mul_a = prod_r[MW-1:0]; mul_b = prod_r[MW-1:0]; end
    endcase
  end

  // Full-width product
  assign mul_p = mul_a * mul_b;

  assign p_ext = {{(DEC_W-PW){1'b0}}, prod_r};
  assign k_ext = {{(DEC_W-SQW){1'b0}}, (reg2_r ? rx2_r : ry2_r)};

  always_comb begin
    unique case (cmd.dec_op)
      DEC_HOLD:   dec_nxt = dec_r;
      DEC_LOAD_P: dec_nxt = p_ext;
      DEC_ADD_P4: dec_nxt = dec_r + (p_ext <<< 2);
      DEC_SUB_P4: dec_nxt = dec_r - (p_ext <<< 2);
      DEC_ADD_P8: dec_nxt = dec_r + (p_ext <<< 3);
      DEC_SUB_P8: dec_nxt = dec_r - (p_ext <<< 3);
      DEC_ADD_K:  dec_nxt = dec_r + (k_ext <<< 2);
      default:    dec_nxt = dec_r;
    endcase
  end

  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_r != '0);

  // Point update and region bookkeeping
  always_comb begin
    x_nxt       = x_r;
    y_nxt       = y_r;
    reg2_nxt    = reg2_r;
    fin_nxt     = fin_r;
    term_ry_nxt = term_ry_r;
    term_rx_nxt = term_rx_r;
    if (cmd.start) begin
      x_nxt    = '0;
      y_nxt    = XW'(radius_y);
      reg2_nxt = 1'b0;
      fin_nxt  = 1'b0;
    end
    if (cmd.step) begin
      if (!reg2_r) begin
        x_nxt = x_r + XW'(1);
        if (dec_neg) begin
          term_ry_nxt = 1'b1;
          term_rx_nxt = 1'b0;
        end else begin
          if (y_r != '0) y_nxt = y_r - XW'(1);
          term_ry_nxt = 1'b1;
          term_rx_nxt = 1'b1;
        end
      end else begin
        if (y_r != '0) y_nxt = y_r - XW'(1);
        if (dec_pos) begin
          term_ry_nxt = 1'b0;
          term_rx_nxt = 1'b1;
        end else begin
          x_nxt       = x_r + XW'(1);
          term_ry_nxt = 1'b1;
          term_rx_nxt = 1'b1;
        end
      end
    end
    if (cmd.set_reg2) reg2_nxt = 1'b1;
    if (cmd.set_fin)  fin_nxt  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      dec_r     <= '0;
      reg2_r    <= 1'b0;
      fin_r     <= 1'b1;
      term_ry_r <= 1'b0;
      term_rx_r <= 1'b0;
    end else begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      dec_r     <= dec_nxt;
      reg2_r    <= reg2_nxt;
      fin_r     <= fin_nxt;
      term_ry_r <= term_ry_nxt;
      term_rx_r <= term_rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.ld_rx2)  rx2_r  <= prod_r[SQW-1:0];
    if (cmd.ld_ry2)  ry2_r  <= prod_r[SQW-1:0];
    if (cmd.ld_hold) hold_r <= prod_r;
  end

  // Pixel coordinates wrap to the output width
  assign cx_c = COORD_BITS'(center_x);
  assign cy_c = COORD_BITS'(center_y);
  assign x_c  = COORD_BITS'(x_r);
  assign y_c  = COORD_BITS'(y_r);
  assign px   = cmd.quad[1] ? cx_c - x_c : cx_c + x_c;
  assign py   = cmd.quad[0] ? cy_c - y_c : cy_c + y_c;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_px_r    <= px;
      out_py_r    <= py;
      out_color_r <= pixel_color;
      out_last_r  <= (cmd.quad == QUAD_LAST);
      out_done_r  <= fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = out_px_r;
  assign out_pixel_y  = out_py_r;
  assign out_color    = out_color_r;
  assign out_last     = out_last_r;
  assign out_done_res = out_done_r;

  assign sts.fin      = fin_r;
  assign sts.reg2     = reg2_r;
  assign sts.lt       = hold_r < prod_r;
  assign sts.done_chk = !((x_r <= XW'(radius_x)) && (y_r != '0));
  assign sts.term_ry  = term_ry_r;
  assign sts.term_rx  = term_rx_r;
  assign sts.out_free = out_free;

endmodule

[rtl/core/mer_ctrl.sv]
module mer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  output logic              in_stall,
  output mer_pkg::dp_cmd_t  cmd,
  input  mer_pkg::dp_sts_t  sts
);
  import mer_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.mul_sel = MUL_RX2;
    cmd.dec_op  = DEC_HOLD;
    cmd.quad    = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_restart) begin
            cmd.start = 1'b1;
            state_nxt = S_R0;
          end else if (!sts.fin) begin
            state_nxt = S_A0;
          end
        end
      end
      // restart: decision = 4*ry^2 - 4*rx^2*ry + rx^2
      S_R0: begin
        cmd.mul_sel = MUL_RX2;
        state_nxt   = S_R1;
      end
      S_R1: begin
        cmd.mul_sel = MUL_RY2;
        cmd.ld_rx2  = 1'b1;
        cmd.dec_op  = DEC_LOAD_P;
        state_nxt   = S_R2;
      end
      S_R2: begin
        cmd.mul_sel = MUL_RX2_Y;
        cmd.ld_ry2  = 1'b1;
        cmd.dec_op  = DEC_ADD_P4;
        state_nxt   = S_R3;
      end
      S_R3: begin
        cmd.dec_op = DEC_SUB_P4;
        state_nxt  = S_S0;
      end
      // advance one step
      S_A0: begin
        cmd.mul_sel = MUL_RX2;
        state_nxt   = S_A1;
      end
      S_A1: begin
        cmd.mul_sel = MUL_RY2;
        cmd.ld_rx2  = 1'b1;
        state_nxt   = S_A2;
      end
      S_A2: begin
        cmd.ld_ry2 = 1'b1;
        cmd.step   = 1'b1;
        state_nxt  = S_A3;
      end
      S_A3: begin
        cmd.mul_sel = MUL_RY2_X;
        cmd.dec_op  = DEC_ADD_K;
        state_nxt   = S_A4;
      end
      S_A4: begin
        cmd.mul_sel = MUL_RX2_Y;
        cmd.dec_op  = sts.term_ry ? DEC_ADD_P8 : DEC_HOLD;
        state_nxt   = S_A5;
      end
      S_A5: begin
        cmd.dec_op = sts.term_rx ? DEC_SUB_P8 : DEC_HOLD;
        state_nxt  = sts.reg2 ? S_CHK : S_S0;
      end
      // region one exit test: ry^2*x < rx^2*y
      S_S0: begin
        cmd.mul_sel = MUL_RY2_X;
        state_nxt   = S_S1;
      end
      S_S1: begin
        cmd.mul_sel = MUL_RX2_Y;
        cmd.ld_hold = 1'b1;
        state_nxt   = S_S2;
      end
      S_S2: begin
        if (sts.lt) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.set_reg2 = 1'b1;
          state_nxt    = S_T0;
        end
      end
      // region two seed: (ry(2x+1))^2 + 4(rx(y-1))^2 - 4(rx*ry)^2
      S_T0: begin
        cmd.mul_sel = MUL_RY_2X1;
        state_nxt   = S_T1;
      end
      S_T1: begin
        cmd.mul_sel = MUL_PSQ;
        state_nxt   = S_T2;
      end
      S_T2: begin
        cmd.mul_sel = MUL_RX_YM1;
        cmd.dec_op  = DEC_LOAD_P;
        state_nxt   = S_T3;
      end
      S_T3: begin
        cmd.mul_sel = MUL_PSQ;
        state_nxt   = S_T4;
      end
      S_T4: begin
        cmd.mul_sel = MUL_RX_RY;
        cmd.dec_op  = DEC_ADD_P4;
        state_nxt   = S_T5;
      end
      S_T5: begin
        cmd.mul_sel = MUL_PSQ;
        state_nxt   = S_T6;
      end
      S_T6: begin
        cmd.dec_op = DEC_SUB_P4;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        cmd.set_fin = sts.done_chk;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          k_nxt    = k_r + 2'd1;
          if (k_r == QUAD_LAST) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("pixel loaded while output register still occupied");

  a_group_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && cmd.emit && k_r == QUAD_LAST) |=> (state_r == S_IDLE && k_r == 2'd0))
    else $error("pixel group did not close after fourth pixel");

  a_finished_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !in_restart && sts.fin) |=> state_r == S_IDLE)
    else $error("advance word on a finished ellipse started work");

endmodule

[rtl/core/midpoint_ellipse_rasterizer_unit.sv]
// Midpoint ellipse rasterizer.
// Program center, radii and color through the APB port while the unit is
// idle. Each input word carries one restart bit: 1 places the current point
// at (0, ry), 0 advances one step along the first-quadrant arc. A word that
// produces a point emits four pixel words on the output channel, in order
// (+x,+y), (+x,-y), (-x,+y), (-x,-y); last marks the fourth, done_res marks
// every pixel of the final point. An advance word after the final point is
// dropped and produces nothing.
// The decision terms are built one product at a time on a single shared
// multiplier, and the four pixels then leave one per cycle while the output
// does not stall. The next input word is taken while the fourth pixel still
// waits in the output register. A stall on the output holds that register
// and stops the sequencer only when it has a pixel to load.
// Reset leaves the register file at its default values and the unit in the
// finished state, so only a restart word draws anything.
module midpoint_ellipse_rasterizer_unit #(
  parameter int RADIUS_BITS = 9,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  // pixel channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_pixel_x,
  output logic signed [COORD_BITS-1:0]  out_pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]   out_color,
  output logic                          out_last,
  output logic                          out_done_res,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mer_pkg::ADDR_W-1:0]    paddr,
  input  logic [mer_pkg::DATA_W-1:0]    pwdata,
  output logic [mer_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import mer_pkg::*;

  logic [CENTER_W-1:0]    center_x;
  logic [CENTER_W-1:0]    center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic [COLOR_W-1:0]     pixel_color;
  dp_cmd_t                cmd;
  dp_sts_t                sts;

  // Register file
  mer_regs #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .pixel_color (pixel_color)
  );

  // Sequencer: walks the multiplier schedule and the four-pixel emit
  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Datapath: point state, decision accumulator, multiplier, output register
  mer_dpath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .pixel_color  (pixel_color),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mer_pkg::*;

  localparam int COORD_W    = 12;
  localparam int RAD_W      = 9;
  localparam int DRAWN_GOAL = 230;   // words that produce a point
  localparam int SETTLE     = 40;    // covers the slowest step with margin
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up

  // One pixel word as it leaves the unit.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               done;
  } pixel_t;

  // Tracks the rasterizer state and the pixel words still owed by the unit.
  class ellipse_scoreboard;
    logic [CENTER_W-1:0] ctr_x, ctr_y;
    logic [RAD_W-1:0]    rad_x, rad_y;
    logic [COLOR_W-1:0]  ink;
    logic [9:0]          pt_x, pt_y;
    logic signed [47:0]  dec;
    bit                  region_two;
    bit                  drawn_out;
    pixel_t              pending[$];
    int                  errors;

    function new();
      ctr_x      = CENTER_X_RST;
      ctr_y      = CENTER_Y_RST;
      rad_x      = RAD_W'(RADIUS_X_RST);
      rad_y      = RAD_W'(RADIUS_Y_RST);
      ink        = COLOR_RST;
      pt_x       = '0;
      pt_y       = '0;
      dec        = '0;
      region_two = 1'b0;
      drawn_out  = 1'b1;
      errors     = 0;
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_CENTER_X:    ctr_x = val[CENTER_W-1:0];
        REG_CENTER_Y:    ctr_y = val[CENTER_W-1:0];
        REG_RADIUS_X:    rad_x = val[RAD_W-1:0];
        REG_RADIUS_Y:    rad_y = val[RAD_W-1:0];
        REG_PIXEL_COLOR: ink   = val[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Step the arc for one accepted input word; return 1 if it yields a point.
    function bit note_word(bit restart);
      longint rx, ry, rx2, ry2, px, py, d, cx, cy;
      bit     fin;
      rx  = rad_x;
      ry  = rad_y;
      rx2 = rx * rx;
      ry2 = ry * ry;
      d   = dec;
      px  = pt_x;
      py  = pt_y;
      fin = 1'b0;
      if (restart) begin
        px         = 0;
        py         = ry;
        region_two = 1'b0;
        drawn_out  = 1'b0;
        d          = 4 * ry2 - 4 * rx2 * ry + rx2;
      end else begin
        if (drawn_out) return 1'b0;
        if (!region_two) begin
          px++;
          if (d < 0) begin
            d += 8 * ry2 * px + 4 * ry2;
          end else begin
            if (py > 0) py--;
            d += 8 * ry2 * px + 4 * ry2 - 8 * rx2 * py;
          end
        end else begin
          if (py > 0) py--;
          if (d > 0) begin
            d += 4 * rx2 - 8 * rx2 * py;
          end else begin
            px++;
            d += 8 * ry2 * px + 4 * rx2 - 8 * rx2 * py;
          end
        end
      end
      // Switch to region two once the slope passes -1, then test for the end.
      if (!region_two && ry2 * px >= rx2 * py) begin
        region_two = 1'b1;
        d = ry2 * (2 * px + 1) * (2 * px + 1) + 4 * rx2 * (py - 1) * (py - 1)
            - 4 * rx2 * ry2;
      end
      if (region_two && !(px <= rx && py > 0)) begin
        drawn_out = 1'b1;
        fin       = 1'b1;
      end
      pt_x = px[9:0];
      pt_y = py[9:0];
      dec  = d[47:0];
      cx   = ctr_x;
      cy   = ctr_y;
      // Quadrant order: (+x,+y), (+x,-y), (-x,+y), (-x,-y).
      for (int q = 0; q < 4; q++) begin
        pixel_t p;
        longint sx, sy;
        sx      = (q < 2) ? cx + px : cx - px;
        sy      = (q[0] == 1'b0) ? cy + py : cy - py;
        p.x     = sx[COORD_W-1:0];
        p.y     = sy[COORD_W-1:0];
        p.color = ink;
        p.last  = (q == 3);
        p.done  = fin;
        pending.push_back(p);
      end
      return 1'b1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) with nothing owed", got.x, got.y));
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x)
        report($sformatf("pixel_x got %0h want %0h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("pixel_y got %0h want %0h", got.y, want.y));
      if (got.color !== want.color)
        report($sformatf("color got %0h want %0h", got.color, want.color));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
      if (got.done !== want.done)
        report($sformatf("done_res got %0b want %0b", got.done, want.done));
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic signed [COORD_W-1:0]  out_pixel_x;
  logic signed [COORD_W-1:0]  out_pixel_y;
  logic [COLOR_W-1:0]         out_color;
  logic                       out_last;
  logic                       out_done_res;
  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [ADDR_W-1:0]          paddr      = '0;
  logic [DATA_W-1:0]          pwdata     = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  ellipse_scoreboard sb;
  int                idle_pct    = 15;  // chance per cycle that a side holds off
  int                words_drawn = 0;
  int                quiet_cnt   = 0;

  midpoint_ellipse_rasterizer_unit #(
    .RADIUS_BITS (RAD_W),
    .COORD_BITS  (COORD_W)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_done_res (out_done_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the pixel channel at random, at the same rate the sender idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Check every pixel word the moment it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel('{x: out_pixel_x, y: out_pixel_y, color: out_color,
                       last: out_last, done: out_done_res});
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake at all.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one input word, idling first at random; keep valid high afterwards
  // so a following word can go back to back.
  task automatic send_word(bit restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    if (sb.note_word(restart)) words_drawn++;
  endtask

  // Drop valid, hold until every owed pixel is back, then let a dropped
  // advance word or a pending step drain out of the sequencer.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready; an idle phase
  // closes the transfer.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_all(int unsigned cx, int unsigned cy, int unsigned rx,
                         int unsigned ry, int unsigned ink);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Y, ry);
    write_reg(REG_PIXEL_COLOR, ink);
  endtask

  // Mostly small radii so ellipses finish quickly; now and then a large one
  // that will be cut short after a few dozen steps.
  function automatic int unsigned pick_radius();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(12);
    if (roll < 90) return $urandom_range(60, 13);
    return $urandom_range(511, 400);
  endfunction

  // One random phase: optionally reprogram, restart (or keep drawing the current
  // arc under the new settings), then advance until done or out of budget.
  task automatic run_phase();
    int budget;
    wait_drain();
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(1)) write_reg(REG_CENTER_X, $urandom_range(1023));
      if ($urandom_range(1)) write_reg(REG_CENTER_Y, $urandom_range(1023));
      if ($urandom_range(1)) write_reg(REG_RADIUS_X, pick_radius());
      if ($urandom_range(1)) write_reg(REG_RADIUS_Y, pick_radius());
      if ($urandom_range(1)) write_reg(REG_PIXEL_COLOR, $urandom_range(15));
    end
    if (sb.drawn_out || $urandom_range(4) != 0) send_word(1'b1);
    budget = $urandom_range(40, 8);
    while (budget > 0 && !sb.drawn_out) begin
      // Restart while drawing now and then.
      send_word($urandom_range(24) == 0);
      budget--;
    end
    // Advance past the end; the unit must drop these.
    if (sb.drawn_out) repeat ($urandom_range(2)) send_word(1'b0);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Advance straight out of reset: nothing to draw yet.
    send_word(1'b0);
    // Default registers, a few steps of the reset ellipse.
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // Degenerate ellipse at the origin: restart group is also the last.
    wait_drain();
    set_all(0, 0, 0, 0, 0);
    send_word(1'b1);
    send_word(1'b0);

    // Largest radii; x side runs past 1023, y side goes negative.
    wait_drain();
    set_all(1023, 0, 511, 511, 15);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    wait_drain();
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 1023);
    send_word(1'b1);
    send_word(1'b0);

    // Zero horizontal radius: region two from the start, run to the end.
    wait_drain();
    set_all(500, 500, 0, 4, 10);
    send_word(1'b1);
    while (!sb.drawn_out) send_word(1'b0);

    // Restart in the middle of a small ellipse, finish, then overshoot.
    wait_drain();
    write_reg(REG_RADIUS_X, 4);
    write_reg(REG_RADIUS_Y, 3);
    send_word(1'b1);
    repeat (2) send_word(1'b0);
    send_word(1'b1);
    while (!sb.drawn_out) send_word(1'b0);
    send_word(1'b0);

    // Flat ellipse: zero vertical radius ends on the restart group.
    wait_drain();
    write_reg(REG_RADIUS_X, 6);
    write_reg(REG_RADIUS_Y, 0);
    send_word(1'b1);

    // Random phases; the first few run with no idling on either side.
    idle_pct = 0;
    for (int n = 0; words_drawn < DRAWN_GOAL; n++) begin
      if (n == 3) idle_pct = 15;
      run_phase();
    end

    wait_drain();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mer_pkg.sv
rtl/core/mer_regs.sv
rtl/core/mer_dpath.sv
rtl/core/mer_ctrl.sv
rtl/core/midpoint_ellipse_rasterizer_unit.sv
tb/tb.sv
